// File: src/kfe_pkg.sv
// Shared types and constants of the keyword field extractor.
// Used by kfe_cell and keyword_field_extractor_core; no dependencies.
`default_nettype none

package kfe_pkg;

  // Default parameter values
  localparam int KEY_MAX_DEF   = 8;
  localparam int POS_WIDTH_DEF = 16;

  // Fixed field widths
  localparam int KEY_BYTES_W = 64;
  localparam int KEY_LEN_W   = 4;
  localparam int BYTE_W      = 8;
  localparam int POS_OUT_W   = 16;
  localparam int CFG_IDX_W   = 2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_BYTES  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_LENGTH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_END_BYTE   = 2'd2;

  localparam logic [BYTE_W-1:0] END_BYTE_RST = 8'd13;
  localparam logic [BYTE_W-1:0] CH_CR        = 8'd13;
  localparam logic [BYTE_W-1:0] CH_LF        = 8'd10;
  localparam logic [BYTE_W-1:0] CH_NUL       = 8'd0;

  typedef enum logic [1:0] {
    PH_SEARCH = 2'd0,
    PH_COPY   = 2'd1,
    PH_SKIP   = 2'd2
  } phase_e;

  typedef enum logic [1:0] {
    K_BYTE     = 2'd0,
    K_TERM     = 2'd1,
    K_NOTFOUND = 2'd2
  } kind_e;

  // Control handed to every window cell
  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctrl_t;

endpackage : kfe_pkg

`default_nettype wire

// File: src/kfe_cell.sv
// One window cell: holds one byte of the sliding window and compares the
// byte it takes in against its keyword byte. Depends on kfe_pkg.
`default_nettype none

module kfe_cell
  import kfe_pkg::*;
#(
  parameter int LEN_W = 4,
  parameter int IDX   = 0
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire cell_ctrl_t             ctrl_i,
  input  wire logic [BYTE_W-1:0]      byte_i,
  input  wire logic [KEY_BYTES_W-1:0] key_bytes_i,
  input  wire logic [LEN_W-1:0]       len_i,
  output logic      [BYTE_W-1:0]      byte_o,
  output logic                        eq_o
);

  logic [BYTE_W-1:0]    win_q, win_d;
  logic                 active;
  logic [KEY_LEN_W-1:0] kidx;
  logic [KEY_BYTES_W-1:0] key_sh;
  logic [BYTE_W-1:0]    key_byte;

  // Newest byte sits in cell 0, so cell IDX matches keyword byte len-1-IDX
  assign active   = KEY_LEN_W'(IDX) < KEY_LEN_W'(len_i);
  assign kidx     = KEY_LEN_W'(len_i) - KEY_LEN_W'(IDX) - KEY_LEN_W'(1);
  assign key_sh   = key_bytes_i >> {kidx[2:0], 3'b000};
  assign key_byte = key_sh[BYTE_W-1:0];
  assign eq_o     = !active || (byte_i == key_byte);

  always_comb begin
    win_d = win_q;
    if (ctrl_i.clear) begin
      win_d = '0;
    end else if (ctrl_i.shift) begin
      win_d = byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= '0;
    end else begin
      win_q <= win_d;
    end
  end

  assign byte_o = win_q;

endmodule : kfe_cell

`default_nettype wire

// File: src/keyword_field_extractor_core.sv
// Keyword field extractor top level: phase control, offset counter, cell
// chain and output register. Depends on kfe_pkg and kfe_cell.
//
// Usage: bytes of a string arrive on the input channel (in_valid_i,
// in_stall_o, data_byte_i); byte 0 ends the string. The block searches for
// the keyword held in key_bytes/key_length, then emits each following byte
// as a field beat (kind 0) until end_byte, CR, LF or the string end, where a
// terminator beat (kind 1) carries the terminator's offset. A string that
// ends before a match gives a not-found beat (kind 2). Bytes that cause no
// beat are simply consumed.
// Throughput: one byte per cycle while in_stall_o is low; the keyword
// compare is done in parallel across the cell chain in the cycle the byte is
// accepted. A result beat is registered and appears on the output channel in
// the cycle after its byte is accepted. The output register lets a new byte
// in while a beat waits; when the receiver holds out_stall_i with a beat
// pending, in_stall_o rises and the beat holds. Reset: phase returns to
// searching, window, counters and output valid clear, key_length and
// key_bytes read 0 and end_byte reads 13. Configuration writes go through
// cfg_we_i/cfg_idx_i/cfg_data_i, by the user only while idle (unenforced).
`default_nettype none

module keyword_field_extractor_core
  import kfe_pkg::*;
#(
  parameter int KEY_MAX   = KEY_MAX_DEF,
  parameter int POS_WIDTH = POS_WIDTH_DEF
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [KEY_BYTES_W-1:0] cfg_data_i,
  input  wire logic                   in_valid_i,
  output logic                        in_stall_o,
  input  wire logic [BYTE_W-1:0]      data_byte_i,
  output logic                        out_valid_o,
  input  wire logic                   out_stall_i,
  output logic      [1:0]             kind_o,
  output logic      [BYTE_W-1:0]      value_o,
  output logic      [POS_OUT_W-1:0]   position_o
);

  localparam int LEN_W  = $clog2(KEY_MAX + 1);
  localparam int PW_EXT = (POS_WIDTH > POS_OUT_W) ? POS_WIDTH : POS_OUT_W;

  // Configuration registers
  logic [KEY_BYTES_W-1:0] key_bytes_q;
  logic [KEY_LEN_W-1:0]   key_length_q;
  logic [BYTE_W-1:0]      end_byte_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_bytes_q  <= '0;
      key_length_q <= '0;
      end_byte_q   <= END_BYTE_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_KEY_BYTES:  key_bytes_q  <= cfg_data_i;
        CFG_KEY_LENGTH: key_length_q <= cfg_data_i[KEY_LEN_W-1:0];
        CFG_END_BYTE:   end_byte_q   <= cfg_data_i[BYTE_W-1:0];
        default: ;
      endcase
    end
  end

  // Control state
  phase_e               phase_q, phase_d;
  logic [LEN_W-1:0]     bytes_seen_q, bytes_seen_d, seen_inc;
  logic [POS_WIDTH-1:0] offset_q, offset_d, offset_inc;

  logic [LEN_W-1:0] len;
  logic             accept, is_nul, is_term, copying, match, restart;
  cell_ctrl_t       cell_ctrl;
  logic [KEY_MAX-1:0] eq;
  logic [BYTE_W-1:0]  win [KEY_MAX];

  // Output register
  logic                 out_valid_q, out_valid_d;
  kind_e                kind_q, kind_d;
  logic [BYTE_W-1:0]    value_q, value_d;
  logic [POS_OUT_W-1:0] pos_q, pos_d, pos_now;
  logic                 emit;
  logic [PW_EXT-1:0]    off_ext;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  assign len = (key_length_q > KEY_LEN_W'(KEY_MAX)) ? LEN_W'(KEY_MAX)
                                                    : LEN_W'(key_length_q);

  assign is_nul  = data_byte_i == CH_NUL;
  assign is_term = is_nul || (data_byte_i == end_byte_q) ||
                   (data_byte_i == CH_CR) || (data_byte_i == CH_LF);
  // An empty keyword turns the current byte into the first field byte
  assign copying = (phase_q == PH_COPY) ||
                   ((phase_q == PH_SEARCH) && (len == '0));

  assign seen_inc   = (bytes_seen_q < LEN_W'(KEY_MAX)) ? bytes_seen_q + LEN_W'(1)
                                                       : bytes_seen_q;
  assign offset_inc = (offset_q != '1) ? offset_q + POS_WIDTH'(1) : offset_q;
  assign match      = (seen_inc >= len) && (&eq);
  assign restart    = accept && is_nul;

  assign cell_ctrl.clear = restart;
  assign cell_ctrl.shift = accept && !copying && (phase_q == PH_SEARCH) && !is_nul;

  // Cell chain: on a shift cell 0 takes the input byte, every other cell its neighbour's
  for (genvar j = 0; j < KEY_MAX; j++) begin : g_cell
    logic [BYTE_W-1:0] cell_in;
    if (j == 0) begin : g_head
      assign cell_in = data_byte_i;
    end else begin : g_link
      assign cell_in = win[j-1];
    end
    kfe_cell #(
      .LEN_W (LEN_W),
      .IDX   (j)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (cell_ctrl),
      .byte_i      (cell_in),
      .key_bytes_i (key_bytes_q),
      .len_i       (len),
      .byte_o      (win[j]),
      .eq_o        (eq[j])
    );
  end

  // Next phase
  always_comb begin
    phase_d = phase_q;
    if (accept) begin
      if (is_nul) begin
        phase_d = PH_SEARCH;
      end else begin
        case (phase_q)
          PH_SKIP: phase_d = PH_SKIP;
          PH_COPY: phase_d = is_term ? PH_SKIP : PH_COPY;
          PH_SEARCH: begin
            if (copying) begin
              phase_d = is_term ? PH_SKIP : PH_COPY;
            end else if (match) begin
              phase_d = PH_COPY;
            end
          end
          default: phase_d = PH_SEARCH;
        endcase
      end
    end
  end

  assign off_ext = PW_EXT'(offset_q);
  assign pos_now = (off_ext > PW_EXT'({POS_OUT_W{1'b1}})) ? {POS_OUT_W{1'b1}}
                                                          : off_ext[POS_OUT_W-1:0];

  // Counters and result beat
  always_comb begin
    bytes_seen_d = bytes_seen_q;
    offset_d     = offset_q;
    emit         = 1'b0;
    kind_d       = kind_q;
    value_d      = value_q;
    pos_d        = pos_q;
    if (accept) begin
      if (is_nul) begin
        bytes_seen_d = '0;
        offset_d     = '0;
      end else begin
        offset_d = offset_inc;
        if (!copying && (phase_q == PH_SEARCH)) begin
          bytes_seen_d = seen_inc;
        end
      end
      if (copying) begin
        emit = 1'b1;
        if (is_term) begin
          kind_d  = K_TERM;
          value_d = '0;
          pos_d   = pos_now;
        end else begin
          kind_d  = K_BYTE;
          value_d = data_byte_i;
          pos_d   = '0;
        end
      end else if ((phase_q == PH_SEARCH) && is_nul) begin
        emit    = 1'b1;
        kind_d  = K_NOTFOUND;
        value_d = '0;
        pos_d   = '0;
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    if (emit) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_SEARCH;
      bytes_seen_q <= '0;
      offset_q     <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      phase_q      <= phase_d;
      bytes_seen_q <= bytes_seen_d;
      offset_q     <= offset_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Payload: load only with a new beat
  always_ff @(posedge clk_i) begin
    if (emit) begin
      kind_q  <= kind_d;
      value_q <= value_d;
      pos_q   <= pos_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign kind_o      = kind_q;
  assign value_o     = value_q;
  assign position_o  = pos_q;

  a_restart_clears : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && is_nul |=> (phase_q == PH_SEARCH) && (offset_q == '0) &&
                         (bytes_seen_q == '0))
    else $error("string end did not restart the search");

  a_seen_bounded : assert property (@(posedge clk_i) disable iff (!rst_ni)
    bytes_seen_q <= LEN_W'(KEY_MAX))
    else $error("window fill count past the window depth");

  a_stall_needs_beat : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with no beat pending");

  a_value_only_bytes : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o != K_BYTE) |-> (value_o == '0))
    else $error("non-field beat carries a value");

  a_pos_only_term : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o != K_TERM) |-> (position_o == '0))
    else $error("non-terminator beat carries a position");

endmodule : keyword_field_extractor_core

`default_nettype wire

// File: test/keyword_field_extractor_core_test.sv
// Testbench of keyword_field_extractor_core: a scoreboard class predicts every
// beat from the accepted bytes and checks the output channel field by field.
// Depends on kfe_pkg and the RTL under src.
`timescale 1ns / 1ps

module keyword_field_extractor_core_test
  import kfe_pkg::*;
();

  localparam logic [CFG_IDX_W-1:0] CFG_NONE = 2'd3;

  typedef struct {
    kind_e                kind;
    logic [BYTE_W-1:0]    value;
    logic [POS_OUT_W-1:0] pos;
  } beat_t;

  class field_scoreboard;
    logic [KEY_BYTES_W-1:0] key_word;
    logic [KEY_LEN_W-1:0]   key_len;
    logic [BYTE_W-1:0]      field_end;
    phase_e                 cur_phase;
    logic [BYTE_W-1:0]      hist[KEY_MAX_DEF];
    int unsigned            hist_fill;
    logic [POS_OUT_W-1:0]   str_pos;
    beat_t                  exp_q[$];
    int                     errors;

    function new();
      key_word  = '0;
      key_len   = '0;
      field_end = END_BYTE_RST;
      errors    = 0;
      restart();
    endfunction

    function void restart();
      cur_phase = PH_SEARCH;
      foreach (hist[i]) hist[i] = '0;
      hist_fill = 0;
      str_pos   = '0;
    endfunction

    function void bump_pos();
      if (str_pos != '1) str_pos++;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [KEY_BYTES_W-1:0] d);
      case (idx)
        CFG_KEY_BYTES:  key_word  = d;
        CFG_KEY_LENGTH: key_len   = d[KEY_LEN_W-1:0];
        CFG_END_BYTE:   field_end = d[BYTE_W-1:0];
        default: ;
      endcase
    endfunction

    function void push(kind_e k, logic [BYTE_W-1:0] v, logic [POS_OUT_W-1:0] p);
      beat_t e;
      e.kind  = k;
      e.value = v;
      e.pos   = p;
      exp_q.push_back(e);
    endfunction

    function void note_byte(logic [BYTE_W-1:0] b);
      int unsigned len;
      bit hit;
      len = (key_len > KEY_MAX_DEF) ? KEY_MAX_DEF : key_len;
      if (cur_phase == PH_SKIP) begin
        if (b == CH_NUL) restart();
        else bump_pos();
        return;
      end
      // an empty keyword means this byte already belongs to the field
      if (cur_phase == PH_SEARCH && len == 0) cur_phase = PH_COPY;
      if (cur_phase == PH_COPY) begin
        if (b == CH_NUL || b == field_end || b == CH_CR || b == CH_LF) begin
          push(K_TERM, '0, str_pos);
          if (b == CH_NUL) begin
            restart();
            return;
          end
          cur_phase = PH_SKIP;
        end else begin
          push(K_BYTE, b, '0);
        end
        bump_pos();
        return;
      end
      if (b == CH_NUL) begin
        push(K_NOTFOUND, '0, '0);
        restart();
        return;
      end
      for (int k = KEY_MAX_DEF - 1; k > 0; k--) hist[k] = hist[k-1];
      hist[0] = b;
      if (hist_fill < KEY_MAX_DEF) hist_fill++;
      // oldest byte of the window slice lines up with keyword byte 0
      hit = (hist_fill >= len);
      for (int k = 0; k < len; k++)
        if (hist[len-1-k] != key_word[8*k +: 8]) hit = 1'b0;
      if (hit) cur_phase = PH_COPY;
      bump_pos();
    endfunction

    task report_mismatch(string msg);
      errors++;
      if (errors <= 40) $display("%0t mismatch: %s", $time, msg);
    endtask

    task check_result(logic [1:0] k, logic [BYTE_W-1:0] v, logic [POS_OUT_W-1:0] p);
      beat_t e;
      if (exp_q.size() == 0) begin
        report_mismatch($sformatf("unexpected beat kind %0d value %02h position %0d",
                                  k, v, p));
        return;
      end
      e = exp_q.pop_front();
      if (k !== e.kind)
        report_mismatch($sformatf("kind %0d, want %0d", k, e.kind));
      if (v !== e.value)
        report_mismatch($sformatf("value %02h, want %02h", v, e.value));
      if (p !== e.pos)
        report_mismatch($sformatf("position %0d, want %0d", p, e.pos));
    endtask
  endclass

  logic                   clk_i = 1'b0;
  logic                   rst_ni;
  logic                   cfg_we_i;
  logic [CFG_IDX_W-1:0]   cfg_idx_i;
  logic [KEY_BYTES_W-1:0] cfg_data_i;
  logic                   in_valid_i;
  logic                   in_stall_o;
  logic [BYTE_W-1:0]      data_byte_i;
  logic                   out_valid_o;
  logic                   out_stall_i;
  logic [1:0]             kind_o;
  logic [BYTE_W-1:0]      value_o;
  logic [POS_OUT_W-1:0]   position_o;

  field_scoreboard sb;
  bit tx_idle_on;
  bit rx_idle_on;
  int long_hold_req;

  keyword_field_extractor_core u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .data_byte_i (data_byte_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .kind_o      (kind_o),
    .value_o     (value_o),
    .position_o  (position_o)
  );

  always #1 clk_i = ~clk_i;

  initial begin
    #2_000_000;
    $display("keyword_field_extractor_core_test: done, errors");
    $finish;
  end

  // Leaves valid high on return so the next byte can follow in the same step.
  task automatic send_byte(logic [BYTE_W-1:0] b);
    if (tx_idle_on && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    data_byte_i <= b;
    do @(posedge clk_i); while (!(in_valid_i && !in_stall_o));
    sb.note_byte(b);
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (sb.exp_q.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [KEY_BYTES_W-1:0] d);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= d;
    @(posedge clk_i);
    sb.set_reg(idx, d);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [BYTE_W-1:0] key_char();
    case ($urandom_range(0, 9))
      0:       return BYTE_W'($urandom_range(0, 255));
      1, 2:    return BYTE_W'($urandom_range(1, 255));
      default: return BYTE_W'(8'h61 + $urandom_range(0, 2));
    endcase
  endfunction

  function automatic logic [BYTE_W-1:0] fill_byte();
    if ($urandom_range(0, 1) == 0) return BYTE_W'(8'h61 + $urandom_range(0, 3));
    return BYTE_W'($urandom_range(1, 255));
  endfunction

  task automatic pick_setting(int ph);
    logic [KEY_BYTES_W-1:0] kw;
    logic [KEY_LEN_W-1:0]   kl;
    logic [BYTE_W-1:0]      eb;
    for (int i = 0; i < 8; i++) kw[8*i +: 8] = key_char();
    case ($urandom_range(0, 5))
      0:       kl = 4'd0;
      1:       kl = 4'd8;
      2:       kl = KEY_LEN_W'($urandom_range(9, 15));
      default: kl = KEY_LEN_W'($urandom_range(1, 4));
    endcase
    case ($urandom_range(0, 4))
      0:       eb = CH_NUL;
      1:       eb = CH_CR;
      2:       eb = 8'hFF;
      default: eb = BYTE_W'($urandom_range(1, 255));
    endcase
    if (ph == 0) begin
      kw = '1;
      kl = 4'd8;
    end else if (ph == 1) begin
      kl = 4'd0;
      eb = 8'hFF;
    end
    write_reg(CFG_KEY_BYTES, kw);
    write_reg(CFG_KEY_LENGTH, KEY_BYTES_W'(kl));
    write_reg(CFG_END_BYTE, KEY_BYTES_W'(eb));
    if ($urandom_range(0, 3) == 0) write_reg(CFG_NONE, {$urandom, $urandom});
  endtask

  // Mostly keyword-bearing strings with random content; the rest noise or
  // strings that stop short of the keyword. Skipped tail bytes are not counted.
  task automatic send_random_string(output int n);
    int unsigned len;
    int mode;
    logic [BYTE_W-1:0] t;
    n    = 0;
    len  = (sb.key_len > KEY_MAX_DEF) ? KEY_MAX_DEF : sb.key_len;
    mode = $urandom_range(0, 9);
    if (mode <= 6) begin
      repeat ($urandom_range(0, 6)) begin
        send_byte(fill_byte());
        n++;
      end
      for (int i = 0; i < len; i++) begin
        send_byte(sb.key_word[8*i +: 8]);
        n++;
      end
      repeat ($urandom_range(0, 10)) begin
        send_byte(fill_byte());
        n++;
      end
      case ($urandom_range(0, 3))
        0:       t = sb.field_end;
        1:       t = CH_CR;
        2:       t = CH_LF;
        default: t = CH_NUL;
      endcase
      send_byte(t);
      n++;
      if (t != CH_NUL) begin
        repeat ($urandom_range(0, 4)) send_byte(fill_byte());
        send_byte(CH_NUL);
      end
    end else if (mode == 7) begin
      for (int i = 0; i + 1 < len; i++) begin
        send_byte(sb.key_word[8*i +: 8]);
        n++;
      end
      send_byte(CH_NUL);
      n++;
    end else begin
      repeat ($urandom_range(1, 12)) begin
        send_byte(BYTE_W'($urandom_range(0, 255)));
        n++;
      end
      send_byte(CH_NUL);
      n++;
    end
  endtask

  // Receiver: checks beats and applies stall bursts and the long hold-off.
  initial begin : rx_side
    int stall_left;
    int hold_left;
    stall_left  = 0;
    hold_left   = 0;
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i)
        sb.check_result(kind_o, value_o, position_o);
      if (long_hold_req > 0) begin
        hold_left     = long_hold_req;
        long_hold_req = 0;
      end
      if (hold_left > 0) hold_left--;
      else if (stall_left > 0) stall_left--;
      else if (rx_idle_on && $urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 15);
      out_stall_i <= (hold_left > 0) || (stall_left > 0);
    end
  end

  initial begin : tx_side
    int n;
    int total;
    int ph_items;
    int ph;
    sb            = new();
    tx_idle_on    = 1'b1;
    rx_idle_on    = 1'b1;
    long_hold_req = 0;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = CFG_KEY_BYTES;
    cfg_data_i    = '0;
    in_valid_i    = 1'b0;
    data_byte_i   = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset values: empty keyword, field ends at CR
    send_text("Hi\r");
    send_byte("z");
    send_byte(CH_NUL);

    wait_idle();
    write_reg(CFG_KEY_BYTES, KEY_BYTES_W'("ba"));
    write_reg(CFG_KEY_LENGTH, 2);
    write_reg(CFG_END_BYTE, KEY_BYTES_W'(";"));
    send_text("xab");
    send_byte(8'hFF);
    send_byte(8'h80);
    send_text(";q");
    send_byte(CH_NUL);
    send_text("aXb");
    send_byte(CH_NUL);
    // string end inside the field
    send_text("ab7");
    send_byte(CH_NUL);

    // end byte of zero: only CR, LF or string end close the field
    wait_idle();
    write_reg(CFG_END_BYTE, KEY_BYTES_W'(CH_NUL));
    send_text("ab;\n");
    send_byte(CH_NUL);

    // oversized key length clamps to the full window; stray index is ignored
    wait_idle();
    write_reg(CFG_KEY_BYTES, "hgfedcba");
    write_reg(CFG_KEY_LENGTH, 15);
    write_reg(CFG_NONE, '1);
    send_text("zabcdefgh!\r");
    send_byte(CH_NUL);

    // zero byte in the keyword can never match
    wait_idle();
    write_reg(CFG_KEY_BYTES, 64'h0061);
    write_reg(CFG_KEY_LENGTH, 2);
    send_text("aa");
    send_byte(CH_NUL);

    // register change part way through a string
    wait_idle();
    write_reg(CFG_KEY_BYTES, KEY_BYTES_W'("ba"));
    send_text("xa");
    wait_idle();
    write_reg(CFG_KEY_LENGTH, 1);
    send_text("bac");
    send_byte(CH_NUL);

    // hold the receiver off while a long field streams in
    wait_idle();
    write_reg(CFG_KEY_LENGTH, 0);
    write_reg(CFG_END_BYTE, KEY_BYTES_W'(CH_CR));
    tx_idle_on    = 1'b0;
    long_hold_req = 300;
    repeat (40) send_byte("p");
    send_byte(CH_LF);
    send_byte(CH_NUL);

    // long string: the keyword turns up well into it
    wait_idle();
    write_reg(CFG_KEY_BYTES, KEY_BYTES_W'("BA"));
    write_reg(CFG_KEY_LENGTH, 2);
    repeat (100) send_byte("x");
    send_text("ABq\r");
    send_byte(CH_NUL);

    total = 0;
    ph    = 0;
    while (total < 750) begin
      wait_idle();
      pick_setting(ph);
      ph++;
      tx_idle_on = ($urandom_range(0, 3) != 0);
      rx_idle_on = ($urandom_range(0, 3) != 0);
      ph_items   = 0;
      while (ph_items < 70) begin
        send_random_string(n);
        ph_items += n;
      end
      total += ph_items;
    end

    // closing stretch at full rate
    wait_idle();
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    pick_setting(ph);
    ph_items = 0;
    while (ph_items < 150) begin
      send_random_string(n);
      ph_items += n;
    end

    wait_idle();
    repeat (10) @(posedge clk_i);
    if (sb.exp_q.size() != 0)
      sb.report_mismatch($sformatf("%0d beats never arrived", sb.exp_q.size()));
    if (sb.errors == 0) begin
      $display("keyword_field_extractor_core_test: done, clean");
    end else begin
      $display("keyword_field_extractor_core_test: done, errors");
    end
    $finish;
  end

endmodule
